### sv/sorted_priority_queue_assert.svh
// Assertion macros for the sorted priority queue
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// check that cons holds in the same cycle as ante
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// check that cons holds in the cycle after ante
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/spq_pkg.sv
// Package with types and constants for the sorted priority queue
`default_nettype none

package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int VALUE_W     = 32;
  localparam int PRIO_W      = 8;
  localparam int OCC_W       = 5;

  typedef enum logic {
    REQ_ENQ = 1'b0,
    REQ_DEQ = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef struct packed {
    req_e                       req_type;
    logic signed [VALUE_W-1:0]  item_value;
    logic        [PRIO_W-1:0]   item_priority;
  } in_t;

  typedef struct packed {
    status_e                    status;
    logic signed [VALUE_W-1:0]  out_value;
    logic        [PRIO_W-1:0]   out_priority;
    logic        [OCC_W-1:0]    occupancy;
  } out_t;

  typedef struct packed {
    logic [VALUE_W-1:0] val;
    logic [PRIO_W-1:0]  prio;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic enq;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### sv/spq_cell.sv
// One slot of the sorted chain: compare against the incoming entry and shift
`default_nettype none

module spq_cell (
  input  wire logic                   clk_i,
  input  wire spq_pkg::cell_ctrl_t    ctrl_i,
  input  wire logic                   occupied_i,
  input  wire spq_pkg::entry_t        new_i,
  input  wire spq_pkg::entry_t        left_i,
  input  wire spq_pkg::entry_t        right_i,
  input  wire logic                   left_ge_i,
  output logic                        ge_o,
  output spq_pkg::entry_t             entry_o
);

  spq_pkg::entry_t entry_q, entry_d;

  assign ge_o = occupied_i && (entry_q.prio >= new_i.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift) begin
      if (ctrl_i.enq) begin
        if (ge_o) begin
          entry_d = entry_q;
        end else if (left_ge_i) begin
          entry_d = new_i;
        end else begin
          entry_d = left_i;
        end
      end else begin
        entry_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

### sv/sorted_priority_queue.sv
// Top level of the sorted priority queue built as a chain of shifting slots
//
// Input channel in_*: one request per transaction, enqueue or dequeue.
// Output channel out_*: one result per request, in request order, with the
// status, the removed value and priority, and the entry count afterwards.
// Every slot compares its priority with the incoming one and all slots shift
// together, so a request is finished in the cycle it is accepted and its
// result appears in the output register in the cycle after.
// Throughput is one request per cycle while the receiver takes results; the
// single output register bounds it.
// An enqueue lands behind all entries of equal or higher priority; an
// enqueue into a full queue and a dequeue from an empty one change nothing.
// Reset empties the queue and drops any pending result; slot contents are
// left as they are and are never read before being written.
// When the receiver stalls, the result is held and no new request is taken
// until it has gone.
`default_nettype none

`include "sorted_priority_queue_assert.svh"

module sorted_priority_queue #(
  parameter int QueueDepth = spq_pkg::QUEUE_DEPTH
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire spq_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output spq_pkg::out_t     out_data_o
);

  localparam int CntW = $clog2(QueueDepth + 1);
  localparam int OccW = spq_pkg::OCC_W;

  logic [CntW-1:0]     count_q, count_d;
  logic                out_valid_q;
  spq_pkg::out_t       out_q, out_d;

  spq_pkg::entry_t     ent [QueueDepth];
  logic                ge  [QueueDepth];
  spq_pkg::entry_t     new_entry;
  spq_pkg::cell_ctrl_t ctrl;

  logic in_fire, is_enq, full, empty;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_enq     = (in_data_i.req_type == spq_pkg::REQ_ENQ);
  assign full       = (count_q == CntW'(QueueDepth));
  assign empty      = (count_q == '0);

  assign new_entry.val  = in_data_i.item_value;
  assign new_entry.prio = in_data_i.item_priority;

  assign ctrl.enq   = is_enq;
  assign ctrl.shift = in_fire && (is_enq ? !full : !empty);

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    spq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occupied_i (CntW'(i) < count_q),
      .new_i      (new_entry),
      .left_i     ((i == 0) ? new_entry : ent[(i == 0) ? 0 : i - 1]),
      .right_i    ((i == QueueDepth - 1) ? ent[i] : ent[(i == QueueDepth - 1) ? i : i + 1]),
      .left_ge_i  ((i == 0) ? 1'b1 : ge[(i == 0) ? 0 : i - 1]),
      .ge_o       (ge[i]),
      .entry_o    (ent[i])
    );
  end

  always_comb begin
    count_d            = count_q;
    out_d              = out_q;
    out_d.out_value    = '0;
    out_d.out_priority = '0;
    if (is_enq) begin
      if (full) begin
        out_d.status = spq_pkg::ST_FULL;
      end else begin
        out_d.status = spq_pkg::ST_INSERTED;
        count_d      = count_q + CntW'(1);
      end
    end else begin
      if (empty) begin
        out_d.status = spq_pkg::ST_EMPTY;
      end else begin
        out_d.status       = spq_pkg::ST_REMOVED;
        out_d.out_value    = ent[0].val;
        out_d.out_priority = ent[0].prio;
        count_d            = count_q - CntW'(1);
      end
    end
    out_d.occupancy = OccW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntW'(QueueDepth),
                  "entry count above depth")
  `SPQ_ASSERT_NEXT(a_deq_removes, in_fire && !is_enq && !empty,
                   out_valid_q && out_q.status == spq_pkg::ST_REMOVED
                   && count_q == $past(count_q) - CntW'(1),
                   "dequeue did not remove")
  `SPQ_ASSERT_NEXT(a_full_holds, in_fire && is_enq && full,
                   $stable(count_q) && out_q.status == spq_pkg::ST_FULL,
                   "full enqueue changed count")
  `SPQ_ASSERT_NOW(a_head_sorted, count_q >= CntW'(2), ent[0].prio >= ent[1].prio,
                  "head slots out of order")

endmodule

`default_nettype wire
